FILE: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned MAX_BYTES      = 16;
  localparam int unsigned MAX_ADDR_BYTES = 8;
  localparam int unsigned BUF_AW         = $clog2(MAX_BYTES);

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_BEGIN = 2'd2;

  localparam logic [15:0] DELAY_RESET = 16'd100;

  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_ST_WAIT = 16'h0002,
    PH_ST_D1   = 16'h0004,
    PH_ST_D2   = 16'h0008,
    PH_ST_D3   = 16'h0010,
    PH_ST_D4   = 16'h0020,
    PH_WB_D1   = 16'h0040,
    PH_WB_D2   = 16'h0080,
    PH_WB_WAIT = 16'h0100,
    PH_RB_D1   = 16'h0200,
    PH_RB_WAIT = 16'h0400,
    PH_RB_D2   = 16'h0800,
    PH_SP_D1   = 16'h1000,
    PH_SP_WAIT = 16'h2000,
    PH_SP_D2   = 16'h4000,
    PH_SP_D3   = 16'h8000
  } phase_e;

  typedef enum logic [4:0] {
    ST_DEV_W = 5'h01,
    ST_REG   = 5'h02,
    ST_WDATA = 5'h04,
    ST_DEV_R = 5'h08,
    ST_RDATA = 5'h10
  } stage_e;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic       busy_res;
    logic [7:0] nack_count;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [BUF_AW-1:0] raddr;
  } buf_req_t;

endpackage

FILE: rtl/core/i2c_master_register_access_top.sv
// The result of a transaction appears on the output register in the cycle after it is accepted.
// One transaction per cycle unless a result stalls; each is a single state update in the sequencer.
// The write buffer RAM is addressed ahead of use, so its registered read adds no stall.
// Reset is asynchronous and active low; it idles the sequencer, clears its line pulls and sets the
// delay register to 100 ticks. The write buffer and the output result register are not cleared.
module i2c_master_register_access_top import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        scl_level_i,
  input  logic        sda_level_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_read_i,
  input  logic [7:0]  device_address_i,
  input  logic [63:0] register_address_i,
  input  logic [3:0]  address_length_i,
  input  logic [4:0]  byte_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_pull_low_o,
  output logic        sda_pull_low_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        read_last_o,
  output logic        done_res_o,
  output logic        busy_res_o,
  output logic [7:0]  nack_count_o,
  output logic        rejected_o
);

  logic [15:0] dly_q;
  logic        ov_q;
  res_t        res_q, res;
  buf_req_t    breq;
  logic [7:0]  buf_rdata;
  logic        acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~ov_q | out_ready_i;
  assign acc         = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= DELAY_RESET;
      ov_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dly_q <= cfg_data_i;
      end
      if (acc) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  i2cm_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (acc),
    .delay_ticks_i      (dly_q),
    .mode_i             (mode_i),
    .scl_level_i        (scl_level_i),
    .sda_level_i        (sda_level_i),
    .data_byte_i        (data_byte_i),
    .is_read_i          (is_read_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .address_length_i   (address_length_i),
    .byte_count_i       (byte_count_i),
    .buf_rdata_i        (buf_rdata),
    .buf_req_o          (breq),
    .res_o              (res)
  );

  i2cm_ram #(
    .Width (8),
    .Depth (MAX_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (breq.we & acc),
    .waddr_i (breq.waddr),
    .wdata_i (breq.wdata),
    .raddr_i (breq.raddr),
    .rdata_o (buf_rdata)
  );

  assign out_valid_o    = ov_q;
  assign scl_pull_low_o = res_q.scl_pull_low;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign read_byte_o    = res_q.read_byte;
  assign read_valid_o   = res_q.read_valid;
  assign read_last_o    = res_q.read_last;
  assign done_res_o     = res_q.done_res;
  assign busy_res_o     = res_q.busy_res;
  assign nack_count_o   = res_q.nack_count;
  assign rejected_o     = res_q.rejected;

endmodule

FILE: rtl/core/i2cm_ram.sv
module i2cm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/i2cm_seq.sv
module i2cm_seq import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [15:0]       delay_ticks_i,
  input  logic [1:0]        mode_i,
  input  logic              scl_level_i,
  input  logic              sda_level_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_read_i,
  input  logic [7:0]        device_address_i,
  input  logic [63:0]       register_address_i,
  input  logic [3:0]        address_length_i,
  input  logic [4:0]        byte_count_i,
  input  logic [7:0]        buf_rdata_i,
  output buf_req_t          buf_req_o,
  output res_t              res_o
);

  phase_e      phase_q, phase_d;
  stage_e      stage_q, stage_d;
  logic [15:0] dcnt_q, dcnt_d;
  logic [3:0]  bitc_q, bitc_d;
  logic [7:0]  shb_q, shb_d;
  logic [4:0]  bidx_q, bidx_d;
  logic [3:0]  abl_q, abl_d;
  logic [63:0] rah_q, rah_d;
  logic [7:0]  dah_q, dah_d;
  logic        rdf_q, rdf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [4:0]  ldc_q, ldc_d;
  logic [7:0]  nack_q, nack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  logic [15:0] dly1;
  logic        dn;
  logic        req_wbyte, req_putbit, req_rbit, req_rbyte, req_stop, req_cond;
  logic        req_enter;
  phase_e      enter_ph;
  logic [7:0]  wbv;
  logic        do_after_ack, do_after_addr;
  logic [3:0]  abl_n;
  logic [4:0]  bidx_n;
  logic [7:0]  rsh;
  logic [2:0]  bsel;
  res_t        res;

  assign dly1 = (delay_ticks_i == 16'd0) ? 16'd1 : delay_ticks_i;
  assign dn   = (dcnt_q <= 16'd1);

  always_comb begin
    phase_d = phase_q;
    stage_d = stage_q;
    dcnt_d  = dcnt_q;
    bitc_d  = bitc_q;
    shb_d   = shb_q;
    bidx_d  = bidx_q;
    abl_d   = abl_q;
    rah_d   = rah_q;
    dah_d   = dah_q;
    rdf_d   = rdf_q;
    cnt_d   = cnt_q;
    ldc_d   = ldc_q;
    nack_d  = nack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    req_wbyte  = 1'b0;
    req_putbit = 1'b0;
    req_rbit   = 1'b0;
    req_rbyte  = 1'b0;
    req_stop   = 1'b0;
    req_cond   = 1'b0;
    req_enter  = 1'b0;
    enter_ph   = PH_IDLE;
    wbv        = 8'h00;
    do_after_ack  = 1'b0;
    do_after_addr = 1'b0;
    abl_n  = abl_q;
    bidx_n = bidx_q + 5'd1;
    rsh    = {shb_q[6:0], sda_level_i};
    bsel   = 3'd0;
    res    = '0;
    buf_req_o.we    = 1'b0;
    buf_req_o.waddr = ldc_q[BUF_AW-1:0];
    buf_req_o.wdata = data_byte_i;
    buf_req_o.raddr = (stage_q == ST_WDATA) ? bidx_n[BUF_AW-1:0] : '0;

    if (!dn) begin
      dcnt_d = dcnt_q - 16'd1;
    end

    case (mode_i)
      MODE_TICK: begin
        unique case (phase_q)
          PH_IDLE: begin
            dcnt_d = dcnt_q;
          end
          PH_ST_WAIT: begin
            dcnt_d = dcnt_q;
            if (scl_level_i) begin
              req_enter = 1'b1;
              enter_ph  = PH_ST_D1;
            end
          end
          PH_ST_D1: begin
            if (dn) begin
              sda_d = 1'b0;
              req_enter = 1'b1;
              enter_ph  = PH_ST_D2;
            end
          end
          PH_ST_D2: begin
            if (dn) begin
              sda_d = 1'b1;
              req_enter = 1'b1;
              enter_ph  = PH_ST_D3;
            end
          end
          PH_ST_D3: begin
            if (dn) begin
              scl_d = 1'b1;
              req_enter = 1'b1;
              enter_ph  = PH_ST_D4;
            end
          end
          PH_ST_D4: begin
            if (dn) begin
              req_wbyte = 1'b1;
              wbv = (stage_q == ST_DEV_R) ? (dah_q | 8'h01) : (dah_q & 8'hfe);
            end
          end
          PH_WB_D1: begin
            if (dn) begin
              scl_d = 1'b0;
              req_enter = 1'b1;
              enter_ph  = PH_WB_D2;
            end
          end
          PH_WB_D2: begin
            if (dn) begin
              phase_d = PH_WB_WAIT;
            end
          end
          PH_WB_WAIT: begin
            dcnt_d = dcnt_q;
            if (scl_level_i) begin
              scl_d = 1'b1;
              if (stage_q == ST_RDATA) begin
                bidx_d = bidx_n;
                if (bidx_n < cnt_q) begin
                  req_rbyte = 1'b1;
                end else begin
                  req_stop = 1'b1;
                end
              end else begin
                shb_d  = {shb_q[6:0], 1'b0};
                bitc_d = bitc_q + 4'd1;
                if (bitc_q < 4'd7) begin
                  req_putbit = 1'b1;
                end else begin
                  req_rbit = 1'b1;
                end
              end
            end
          end
          PH_RB_D1: begin
            if (dn) begin
              scl_d   = 1'b0;
              phase_d = PH_RB_WAIT;
            end
          end
          PH_RB_WAIT: begin
            dcnt_d = dcnt_q;
            if (scl_level_i) begin
              req_enter = 1'b1;
              enter_ph  = PH_RB_D2;
            end
          end
          PH_RB_D2: begin
            if (dn) begin
              scl_d = 1'b1;
              if (stage_q == ST_RDATA) begin
                bitc_d = bitc_q + 4'd1;
                if (bitc_q < 4'd7) begin
                  shb_d    = rsh;
                  req_rbit = 1'b1;
                end else begin
                  res.read_byte  = rsh;
                  res.read_valid = 1'b1;
                  res.read_last  = (bidx_n == cnt_q);
                  shb_d  = (bidx_n == cnt_q) ? 8'h80 : 8'h00;
                  bitc_d = 4'd7;
                  req_putbit = 1'b1;
                end
              end else begin
                if (sda_level_i) begin
                  nack_d = nack_q + 8'd1;
                end
                do_after_ack = 1'b1;
              end
            end
          end
          PH_SP_D1: begin
            if (dn) begin
              scl_d   = 1'b0;
              phase_d = PH_SP_WAIT;
            end
          end
          PH_SP_WAIT: begin
            dcnt_d = dcnt_q;
            if (scl_level_i) begin
              req_enter = 1'b1;
              enter_ph  = PH_SP_D2;
            end
          end
          PH_SP_D2: begin
            if (dn) begin
              sda_d = 1'b0;
              req_enter = 1'b1;
              enter_ph  = PH_SP_D3;
            end
          end
          PH_SP_D3: begin
            if (dn) begin
              phase_d = PH_IDLE;
              res.done_res = 1'b1;
            end
          end
          default: begin
            dcnt_d = dcnt_q;
          end
        endcase
      end
      MODE_LOAD: begin
        dcnt_d = dcnt_q;
        if (phase_q != PH_IDLE || ldc_q >= 5'(MAX_BYTES)) begin
          res.rejected = 1'b1;
        end else begin
          buf_req_o.we = 1'b1;
          ldc_d = ldc_q + 5'd1;
        end
      end
      MODE_BEGIN: begin
        dcnt_d = dcnt_q;
        if (phase_q != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          rdf_d  = is_read_i;
          dah_d  = device_address_i;
          rah_d  = register_address_i;
          abl_d  = (address_length_i > 4'(MAX_ADDR_BYTES)) ? 4'(MAX_ADDR_BYTES)
                                                            : address_length_i;
          cnt_d  = (byte_count_i > 5'(MAX_BYTES)) ? 5'(MAX_BYTES) : byte_count_i;
          ldc_d  = 5'd0;
          nack_d = 8'd0;
          bidx_d = 5'd0;
          bitc_d = 4'd0;
          stage_d  = ST_DEV_W;
          req_cond = 1'b1;
        end
      end
      default: begin
        dcnt_d = dcnt_q;
      end
    endcase

    if (do_after_ack) begin
      case (stage_q)
        ST_DEV_W: begin
          do_after_addr = 1'b1;
        end
        ST_REG: begin
          abl_n = abl_q - 4'd1;
          abl_d = abl_n;
          do_after_addr = 1'b1;
        end
        ST_WDATA: begin
          bidx_d = bidx_n;
          if (bidx_n < cnt_q && bidx_n < 5'(MAX_BYTES)) begin
            req_wbyte = 1'b1;
            wbv = buf_rdata_i;
          end else begin
            req_stop = 1'b1;
          end
        end
        default: begin
          if (cnt_q != 5'd0) begin
            stage_d = ST_RDATA;
            bidx_d  = 5'd0;
            req_rbyte = 1'b1;
          end else begin
            req_stop = 1'b1;
          end
        end
      endcase
    end

    if (do_after_addr) begin
      if (abl_n != 4'd0) begin
        bsel = 3'(abl_n - 4'd1);
        stage_d   = ST_REG;
        req_wbyte = 1'b1;
        wbv = rah_q[{bsel, 3'b000} +: 8];
      end else if (rdf_q) begin
        stage_d  = ST_DEV_R;
        req_cond = 1'b1;
      end else if (cnt_q != 5'd0) begin
        stage_d   = ST_WDATA;
        bidx_d    = 5'd0;
        req_wbyte = 1'b1;
        wbv = buf_rdata_i;
      end else begin
        req_stop = 1'b1;
      end
    end

    if (req_wbyte) begin
      shb_d  = wbv;
      bitc_d = 4'd0;
      req_putbit = 1'b1;
    end
    if (req_putbit) begin
      sda_d = ~shb_d[7];
      req_enter = 1'b1;
      enter_ph  = PH_WB_D1;
    end
    if (req_rbyte) begin
      shb_d  = 8'h00;
      bitc_d = 4'd0;
      req_rbit = 1'b1;
    end
    if (req_rbit) begin
      sda_d = 1'b0;
      req_enter = 1'b1;
      enter_ph  = PH_RB_D1;
    end
    if (req_stop) begin
      sda_d = 1'b1;
      req_enter = 1'b1;
      enter_ph  = PH_SP_D1;
    end
    if (req_cond) begin
      scl_d   = 1'b0;
      phase_d = PH_ST_WAIT;
    end
    if (req_enter) begin
      phase_d = enter_ph;
      dcnt_d  = dly1;
    end

    res.scl_pull_low = scl_d;
    res.sda_pull_low = sda_d;
    res.busy_res     = (phase_d != PH_IDLE);
    res.nack_count   = nack_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      stage_q <= ST_DEV_W;
      dcnt_q  <= '0;
      bitc_q  <= '0;
      shb_q   <= '0;
      bidx_q  <= '0;
      abl_q   <= '0;
      rah_q   <= '0;
      dah_q   <= '0;
      rdf_q   <= 1'b0;
      cnt_q   <= '0;
      ldc_q   <= '0;
      nack_q  <= '0;
      scl_q   <= 1'b0;
      sda_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      dcnt_q  <= dcnt_d;
      bitc_q  <= bitc_d;
      shb_q   <= shb_d;
      bidx_q  <= bidx_d;
      abl_q   <= abl_d;
      rah_q   <= rah_d;
      dah_q   <= dah_d;
      rdf_q   <= rdf_d;
      cnt_q   <= cnt_d;
      ldc_q   <= ldc_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

FILE: rtl/core/i2cm_chk.sv
module i2cm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_byte_o,
  input logic       read_valid_o,
  input logic       read_last_o,
  input logic       done_res_o,
  input logic       busy_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o))
    else $error("Output transaction changed while stalled.");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input held off while the output register was free.");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_last_o |-> read_valid_o && busy_res_o)
    else $error("Last flag without a read byte.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !read_valid_o)
    else $error("Stop completed while still busy.");

endmodule

bind i2c_master_register_access_top i2cm_chk u_i2cm_chk (.*);

FILE: tb/i2c_master_register_access_top_tb.sv
module i2c_master_register_access_top_tb;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 5000;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_ST_WAIT, SQ_ST_D1, SQ_ST_D2, SQ_ST_D3, SQ_ST_D4, SQ_WB_D1, SQ_WB_D2,
    SQ_WB_WAIT, SQ_RB_D1, SQ_RB_WAIT, SQ_RB_D2, SQ_SP_D1, SQ_SP_WAIT, SQ_SP_D2, SQ_SP_D3
  } seq_e;

  typedef enum logic [2:0] {GR_DEV_W, GR_REG, GR_WDATA, GR_DEV_R, GR_RDATA} grp_e;

  typedef struct {
    logic [1:0]  mode;
    logic        scl;
    logic        sda;
    logic [7:0]  data;
    logic        is_read;
    logic [7:0]  dev;
    logic [63:0] reg_addr;
    logic [3:0]  alen;
    logic [4:0]  bcnt;
  } item_t;

  typedef struct {
    seq_e        ph;
    grp_e        stg;
    int unsigned dly;
    int unsigned dcnt;
    int unsigned bitn;
    int unsigned bidx;
    int unsigned abl;
    int unsigned cnt;
    int unsigned lcnt;
    logic [7:0]  sh;
    logic [7:0]  dev;
    logic [7:0]  nacks;
    logic [63:0] ra;
    bit          rd;
    logic [7:0]  buff [MAX_BYTES];
    bit          scl_d;
    bit          sda_d;
    logic [7:0]  o_byte;
    bit          o_valid;
    bit          o_last;
    bit          o_done;
  } i2c_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid;
  logic [1:0]  mode;
  logic        scl_level, sda_level, is_read;
  logic [7:0]  data_byte, device_address;
  logic [63:0] register_address;
  logic [3:0]  address_length;
  logic [4:0]  byte_count;
  logic        out_ready;
  logic        cfg_ready, in_ready, out_valid;
  res_t        got;

  i2c_state_t  gen_st, chk_st;
  item_t       pending [$];
  res_t        bus_expect [$];
  int          errors = 0;
  int          nitems = 0;
  int          wmax = 0;
  bit          idle_on = 1'b0;
  int          hold_left = 0;
  int          in_gap, out_stall, quiet;

  i2c_master_register_access_top u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .scl_level_i(scl_level), .sda_level_i(sda_level),
    .data_byte_i(data_byte), .is_read_i(is_read), .device_address_i(device_address),
    .register_address_i(register_address), .address_length_i(address_length),
    .byte_count_i(byte_count),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .scl_pull_low_o(got.scl_pull_low), .sda_pull_low_o(got.sda_pull_low),
    .read_byte_o(got.read_byte), .read_valid_o(got.read_valid),
    .read_last_o(got.read_last), .done_res_o(got.done_res), .busy_res_o(got.busy_res),
    .nack_count_o(got.nack_count), .rejected_o(got.rejected)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void reset_state(inout i2c_state_t m);
    m.ph = SQ_IDLE; m.stg = GR_DEV_W; m.dly = DELAY_RESET; m.dcnt = 0; m.bitn = 0;
    m.bidx = 0; m.abl = 0; m.cnt = 0; m.lcnt = 0; m.sh = '0; m.dev = '0; m.nacks = '0;
    m.ra = '0; m.rd = 0; m.scl_d = 0; m.sda_d = 0;
    foreach (m.buff[i]) m.buff[i] = '0;
  endfunction

  function automatic void enter_delay(inout i2c_state_t m, input seq_e p);
    m.ph = p;
    m.dcnt = (m.dly != 0) ? m.dly : 1;
  endfunction

  function automatic bit delay_done(inout i2c_state_t m);
    if (m.dcnt > 1) begin
      m.dcnt--;
      return 0;
    end
    return 1;
  endfunction

  function automatic void put_bit(inout i2c_state_t m);
    m.sda_d = !m.sh[7];
    enter_delay(m, SQ_WB_D1);
  endfunction

  function automatic void send_byte(inout i2c_state_t m, input logic [7:0] b);
    m.sh = b;
    m.bitn = 0;
    put_bit(m);
  endfunction

  function automatic void recv_bit(inout i2c_state_t m);
    m.sda_d = 0;
    enter_delay(m, SQ_RB_D1);
  endfunction

  function automatic void recv_byte(inout i2c_state_t m);
    m.sh = '0;
    m.bitn = 0;
    recv_bit(m);
  endfunction

  function automatic void begin_stop(inout i2c_state_t m);
    m.sda_d = 1;
    enter_delay(m, SQ_SP_D1);
  endfunction

  function automatic void next_after_address(inout i2c_state_t m);
    if (m.abl > 0) begin
      m.stg = GR_REG;
      send_byte(m, 8'(m.ra >> (8 * ((m.abl - 1) & 7))));
    end else if (m.rd) begin
      m.stg = GR_DEV_R;
      m.scl_d = 0;
      m.ph = SQ_ST_WAIT;
    end else if (m.cnt > 0) begin
      m.stg = GR_WDATA;
      m.bidx = 0;
      send_byte(m, m.buff[0]);
    end else begin
      begin_stop(m);
    end
  endfunction

  function automatic void next_after_ack(inout i2c_state_t m);
    case (m.stg)
      GR_DEV_W: next_after_address(m);
      GR_REG: begin
        m.abl--;
        next_after_address(m);
      end
      GR_WDATA: begin
        m.bidx++;
        if (m.bidx < m.cnt && m.bidx < MAX_BYTES) send_byte(m, m.buff[m.bidx]);
        else begin_stop(m);
      end
      default: begin
        if (m.cnt > 0) begin
          m.stg = GR_RDATA;
          m.bidx = 0;
          recv_byte(m);
        end else begin
          begin_stop(m);
        end
      end
    endcase
  endfunction

  function automatic void line_tick(inout i2c_state_t m, input bit scl, input bit sda);
    bit last;
    case (m.ph)
      SQ_ST_WAIT: if (scl) enter_delay(m, SQ_ST_D1);
      SQ_ST_D1: if (delay_done(m)) begin m.sda_d = 0; enter_delay(m, SQ_ST_D2); end
      SQ_ST_D2: if (delay_done(m)) begin m.sda_d = 1; enter_delay(m, SQ_ST_D3); end
      SQ_ST_D3: if (delay_done(m)) begin m.scl_d = 1; enter_delay(m, SQ_ST_D4); end
      SQ_ST_D4: if (delay_done(m)) send_byte(m, (m.stg == GR_DEV_R) ? (m.dev | 8'h01)
                                                                      : (m.dev & 8'hfe));
      SQ_WB_D1: if (delay_done(m)) begin m.scl_d = 0; enter_delay(m, SQ_WB_D2); end
      SQ_WB_D2: if (delay_done(m)) m.ph = SQ_WB_WAIT;
      SQ_WB_WAIT: begin
        if (scl) begin
          m.scl_d = 1;
          if (m.stg == GR_RDATA) begin
            m.bidx++;
            if (m.bidx < m.cnt) recv_byte(m);
            else begin_stop(m);
          end else begin
            m.sh = m.sh << 1;
            m.bitn++;
            if (m.bitn < 8) put_bit(m);
            else recv_bit(m);
          end
        end
      end
      SQ_RB_D1: if (delay_done(m)) begin m.scl_d = 0; m.ph = SQ_RB_WAIT; end
      SQ_RB_WAIT: if (scl) enter_delay(m, SQ_RB_D2);
      SQ_RB_D2: begin
        if (delay_done(m)) begin
          m.scl_d = 1;
          if (m.stg == GR_RDATA) begin
            m.sh = {m.sh[6:0], sda};
            m.bitn++;
            if (m.bitn < 8) begin
              recv_bit(m);
            end else begin
              last = (m.bidx + 1 == m.cnt);
              m.o_byte = m.sh;
              m.o_valid = 1;
              m.o_last = last;
              m.sh = last ? 8'h80 : 8'h00;
              m.bitn = 7;
              put_bit(m);
            end
          end else begin
            if (sda) m.nacks = m.nacks + 8'd1;
            next_after_ack(m);
          end
        end
      end
      SQ_SP_D1: if (delay_done(m)) begin m.scl_d = 0; m.ph = SQ_SP_WAIT; end
      SQ_SP_WAIT: if (scl) enter_delay(m, SQ_SP_D2);
      SQ_SP_D2: if (delay_done(m)) begin m.sda_d = 0; enter_delay(m, SQ_SP_D3); end
      SQ_SP_D3: if (delay_done(m)) begin m.ph = SQ_IDLE; m.o_done = 1; end
      default: ;
    endcase
  endfunction

  function automatic res_t predict_lines(inout i2c_state_t m, input item_t it);
    res_t r;
    bit rej;
    rej = 0;
    m.o_byte = '0; m.o_valid = 0; m.o_last = 0; m.o_done = 0;
    case (it.mode)
      MODE_TICK: line_tick(m, it.scl, it.sda);
      MODE_LOAD: begin
        if (m.ph != SQ_IDLE || m.lcnt >= MAX_BYTES) begin
          rej = 1;
        end else begin
          m.buff[m.lcnt] = it.data;
          m.lcnt++;
        end
      end
      MODE_BEGIN: begin
        if (m.ph != SQ_IDLE) begin
          rej = 1;
        end else begin
          m.rd = it.is_read;
          m.dev = it.dev;
          m.ra = it.reg_addr;
          m.abl = (it.alen > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES : it.alen;
          m.cnt = (it.bcnt > MAX_BYTES) ? MAX_BYTES : it.bcnt;
          m.lcnt = 0; m.nacks = '0; m.bidx = 0; m.bitn = 0;
          m.stg = GR_DEV_W;
          m.scl_d = 0;
          m.ph = SQ_ST_WAIT;
        end
      end
      default: ;
    endcase
    r.scl_pull_low = m.scl_d;
    r.sda_pull_low = m.sda_d;
    r.read_byte = m.o_byte;
    r.read_valid = m.o_valid;
    r.read_last = m.o_last;
    r.done_res = m.o_done;
    r.busy_res = (m.ph != SQ_IDLE);
    r.nack_count = m.nacks;
    r.rejected = rej;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0; mode <= MODE_TICK; scl_level <= 1'b0; sda_level <= 1'b0;
      data_byte <= '0; is_read <= 1'b0; device_address <= '0; register_address <= '0;
      address_length <= '0; byte_count <= '0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        it.mode = mode; it.scl = scl_level; it.sda = sda_level; it.data = data_byte;
        it.is_read = is_read; it.dev = device_address; it.reg_addr = register_address;
        it.alen = address_length; it.bcnt = byte_count;
        bus_expect.push_back(predict_lines(chk_st, it));
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          mode <= it.mode; scl_level <= it.scl; sda_level <= it.sda; data_byte <= it.data;
          is_read <= it.is_read; device_address <= it.dev; register_address <= it.reg_addr;
          address_length <= it.alen; byte_count <= it.bcnt;
          in_valid <= 1'b1;
          in_gap = idle_on ? $urandom_range(0, 19) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          errors++;
        end else begin
          e = bus_expect.pop_front();
          check_field("scl_pull_low", e.scl_pull_low, got.scl_pull_low);
          check_field("sda_pull_low", e.sda_pull_low, got.sda_pull_low);
          check_field("read_byte", e.read_byte, got.read_byte);
          check_field("read_valid", e.read_valid, got.read_valid);
          check_field("read_last", e.read_last, got.read_last);
          check_field("done_res", e.done_res, got.done_res);
          check_field("busy_res", e.busy_res, got.busy_res);
          check_field("nack_count", e.nack_count, got.nack_count);
          check_field("rejected", e.rejected, got.rejected);
        end
        out_stall = idle_on ? $urandom_range(0, 19) : 0;
      end else if (out_stall > 0) begin
        out_stall--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (out_stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL i2c_master_register_access_top");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t random_item(logic [1:0] m);
    item_t it;
    it.mode = m;
    it.scl = $urandom_range(0, 1);
    it.sda = $urandom_range(0, 1);
    it.data = $urandom_range(0, 255);
    it.is_read = $urandom_range(0, 1);
    it.dev = $urandom_range(0, 255);
    it.reg_addr = {$urandom, $urandom};
    it.alen = $urandom_range(0, 15);
    it.bcnt = $urandom_range(0, 31);
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    res_t r;
    if (it.mode == MODE_BEGIN && gen_st.ph == SQ_IDLE && !it.is_read) begin
      if (((it.bcnt > MAX_BYTES) ? MAX_BYTES : it.bcnt) > wmax) it.bcnt = wmax;
    end
    if (it.mode == MODE_LOAD && gen_st.ph == SQ_IDLE && gen_st.lcnt < MAX_BYTES &&
        gen_st.lcnt + 1 > wmax) wmax = gen_st.lcnt + 1;
    pending.push_back(it);
    r = predict_lines(gen_st, it);
    nitems++;
  endfunction

  function automatic void queue_loads(int n);
    repeat (n) queue_item(random_item(MODE_LOAD));
  endfunction

  function automatic void queue_transfer(bit rd, logic [7:0] dev, int al, int bc, int noise);
    item_t it;
    it = random_item(MODE_BEGIN);
    it.is_read = rd; it.dev = dev; it.alen = al; it.bcnt = bc;
    queue_item(it);
    while (gen_st.ph != SQ_IDLE) begin
      if ($urandom_range(0, 99) < noise) begin
        queue_item(random_item($urandom_range(1, 3)));
      end else begin
        it = random_item(MODE_TICK);
        it.scl = ($urandom_range(0, 4) != 0);
        queue_item(it);
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending.size() > 0 || in_valid || bus_expect.size() > 0);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_delay(logic [15:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_st.dly = v;
    chk_st.dly = v;
    @(negedge clk_i);
  endtask

  initial begin
    int target;
    reset_state(gen_st);
    reset_state(chk_st);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(random_item(MODE_TICK));
    queue_item(random_item(2'd3));
    queue_loads(3);
    queue_transfer(1'b1, 8'h5a, 0, 0, 0);
    wait_drained();

    write_delay(16'd1);
    queue_loads(16);
    queue_loads(2);
    queue_transfer(1'b0, 8'hff, 15, 31, 5);
    queue_transfer(1'b1, 8'h00, 0, 0, 5);
    queue_transfer(1'b1, 8'ha5, 8, 16, 0);
    queue_transfer(1'b0, 8'h3c, 0, 0, 0);
    queue_transfer(1'b1, 8'h81, 2, 31, 3);
    wait_drained();

    write_delay(16'hffff);
    idle_on = 1'b1;
    queue_loads(20);
    repeat (20) queue_item(random_item($urandom_range(0, 1) ? MODE_TICK : 2'd3));
    wait_drained();

    write_delay(16'd2);
    target = nitems + 1300;
    while (nitems < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        queue_loads($urandom_range(0, 9) == 0 ? $urandom_range(10, 18) : $urandom_range(0, 4));
        queue_transfer($urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 9) == 0 ? $urandom_range(4, 15) : $urandom_range(0, 2),
                       $urandom_range(0, 9) == 0 ? $urandom_range(4, 31) : $urandom_range(0, 3),
                       $urandom_range(0, 1) ? 0 : 8);
      end else begin
        repeat ($urandom_range(1, 6)) queue_item(random_item($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 15) == 0) begin
        hold_left = 300;
        wait_drained();
      end else if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
    wait_drained();

    if (errors == 0) begin
      $display("PASS i2c_master_register_access_top");
    end else begin
      $display("FAIL i2c_master_register_access_top");
    end
    $finish;
  end

endmodule
